@@ rtl/taas_pkg.sv @@
// Shared types and constants for the tip auto-approach sequencer.
package taas_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_READY   = 3'd0,
    PH_EXTEND  = 3'd1,
    PH_RETRACT = 3'd2,
    PH_DELAY1  = 3'd3,
    PH_STEP    = 3'd4,
    PH_DELAY2  = 3'd5
  } phase_t;

  localparam logic [2:0] REG_MOVER_MODE    = 3'd0;
  localparam logic [2:0] REG_WAVE_LENGTH   = 3'd1;
  localparam logic [2:0] REG_PHASE_OFFSET  = 3'd2;
  localparam logic [2:0] REG_SLOW_DOWN     = 3'd3;
  localparam logic [2:0] REG_STEP_TARGET   = 3'd4;
  localparam logic [2:0] REG_DELAY_TICKS   = 3'd5;
  localparam logic [2:0] REG_CONFIRM_TICKS = 3'd6;
  localparam logic [2:0] REG_CI_MULTIPLIER = 3'd7;

  localparam int CFG_W = 16;

  // The table is addressed with 12 bits, so its depth is fixed.
  localparam int WAVE_DEPTH = 4096;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] z_position;
    logic               error_positive;
    logic signed [15:0] ci_now;
    logic signed [15:0] cp_now;
    logic [11:0]        wave_index;
    logic signed [15:0] wave_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] x_drive;
    logic signed [15:0] y_drive;
    logic signed [15:0] ci_request;
    logic signed [15:0] cp_request;
    logic               feedback_on;
    logic [2:0]         phase;
    logic               busy_res;
  } out_word_t;

  // Per-word decision from the front part, carried with the word.
  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         drive_sel;   // bit0 write x, bit1 write y
    logic [1:0]         drive_neg;
    logic [1:0]         drive_zero;
    logic               rd_x;
    logic               rd_y;
    logic               next_x_zero;
    logic               next_y_zero;
    logic               clear_after;
    logic signed [15:0] ci_req;
    logic signed [15:0] cp_req;
    logic               feedback_on;
    logic [2:0]         phase;
    logic               busy;
  } job_t;

endpackage

@@ rtl/taas_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module taas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

@@ rtl/taas_front.sv @@
// Front part: holds the sequencer state, classifies each word and issues table reads.
module taas_front
  import taas_pkg::*;
#(
  parameter int AW = 12,
  parameter int ZLIM = 30000
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic            in_take,
  input  in_word_t        in_w,
  output job_t            job,
  output logic            rd_x_en,
  output logic            rd_y_en,
  output logic [AW-1:0]   rd_x_addr,
  output logic [AW-1:0]   rd_y_addr
);
  logic [5:0]  mode_reg;
  logic [12:0] wave_length;
  logic [11:0] phase_offset;
  logic [15:0] slow_down, step_target, delay_ticks, confirm_ticks;
  logic [7:0]  ci_multiplier;

  logic [2:0]  tip_phase;
  logic        running, gain_neg, pid_enable, gain_override;
  logic [15:0] confirm_count, steps_done;
  logic [16:0] delay_count, divider_count;
  logic [11:0] sample_pos;
  logic signed [15:0] saved_ci, saved_cp;
  // Saturated override gain for the saved value and for a gain captured this word.
  logic signed [15:0] ovr_now, ovr_cap;

  logic [2:0]  tip_phase_next;
  logic        running_next, gain_neg_next, pid_enable_next, gain_override_next;
  logic [15:0] confirm_count_next, steps_done_next;
  logic [16:0] delay_count_next, divider_count_next;
  logic [11:0] sample_pos_next;
  logic signed [15:0] saved_ci_next, saved_cp_next;
  logic        restored, capture;

  logic signed [15:0] ci_eff, cp_eff;
  logic signed [16:0] sz, sci;
  logic [13:0] t_sum;
  logic [12:0] t_pos;
  logic [12:0] rx_a, ry_a;
  logic        dx_w, dy_w, dx_n, dy_n, dx_z, dy_z, rdx, rdy, nxz, nyz, clr;

  function automatic logic signed [15:0] ovr_sat(logic signed [15:0] g, logic [7:0] m);
    logic signed [24:0] p;
    p = -(25'(g) * $signed({17'd0, m}));
    if (p > 25'sd32767) p = 25'sd32767;
    else if (p < -25'sd32768) p = -25'sd32768;
    return p[15:0];
  endfunction

  assign ovr_now = ovr_sat(saved_ci, ci_multiplier);
  assign ovr_cap = ovr_sat(in_w.ci_now, ci_multiplier);

  always_comb begin
    logic [12:0] pos13;
    logic [16:0] div_dec;
    logic [15:0] steps_inc;
    logic        wave_on;
    logic        div_done;
    ci_eff = gain_override ? ovr_now : in_w.ci_now;
    cp_eff = gain_override ? 16'sd0 : in_w.cp_now;
    sz  = gain_neg ? -17'(in_w.z_position) : 17'(in_w.z_position);
    sci = gain_neg ? -17'(ci_eff) : 17'(ci_eff);

    tip_phase_next = tip_phase;
    running_next = running;
    gain_neg_next = gain_neg;
    pid_enable_next = pid_enable;
    gain_override_next = gain_override;
    confirm_count_next = confirm_count;
    steps_done_next = steps_done;
    delay_count_next = delay_count;
    divider_count_next = divider_count;
    sample_pos_next = sample_pos;
    saved_ci_next = saved_ci;
    saved_cp_next = saved_cp;
    restored = 1'b0;
    capture = 1'b0;
    dx_w = 1'b0; dy_w = 1'b0; dx_n = 1'b0; dy_n = 1'b0; dx_z = 1'b0; dy_z = 1'b0;
    rdx = 1'b0; rdy = 1'b0; nxz = 1'b0; nyz = 1'b0; clr = 1'b0;

    pos13 = {1'b0, sample_pos};
    t_sum = 14'(pos13) + 14'(phase_offset);
    t_pos = (t_sum >= 14'(wave_length)) ? 13'(t_sum - 14'(wave_length)) : 13'(t_sum);
    wave_on = mode_reg[4];
    rx_a = pos13;
    ry_a = t_pos;
    div_dec = divider_count - 17'd1;
    div_done = !(div_dec != 17'd0 && !div_dec[16]);
    steps_inc = steps_done + 16'd1;

    case (op_t'(in_w.operation))
      OP_TICK: begin
        if (running) begin
          if (!mode_reg[5] || tip_phase == PH_STEP) begin
            // Mover job.
            if (wave_on) begin
              case (mode_reg[2:0])
                3'd1: begin
                  dx_w = 1'b1; rdx = 1'b1;
                  if (mode_reg[3]) begin dy_w = 1'b1; rdy = 1'b1; end
                end
                3'd2: begin
                  if (mode_reg[3]) begin
                    dx_w = 1'b1; dy_w = 1'b1; rdx = 1'b1; rdy = 1'b1;
                    rx_a = wave_length - pos13 - 13'd1;
                    ry_a = wave_length - t_pos - 13'd1;
                  end else begin
                    dx_w = 1'b1; dx_n = 1'b1; rdx = 1'b1;
                  end
                end
                3'd3: begin dy_w = 1'b1; rdy = 1'b1; ry_a = pos13; end
                3'd4: begin dy_w = 1'b1; dy_n = 1'b1; rdy = 1'b1; ry_a = pos13; end
                3'd0: begin dx_w = 1'b1; dy_w = 1'b1; dx_z = 1'b1; dy_z = 1'b1; end
                default: ;
              endcase
              divider_count_next = div_dec;
              if (div_done) begin
                divider_count_next = {1'b0, slow_down};
                if (13'(sample_pos) + 13'd1 >= wave_length || sample_pos == 12'hfff)
                  sample_pos_next = '0;
                else
                  sample_pos_next = sample_pos + 12'd1;
              end
            end
            // In wave mode a step is only counted when the divider runs out.
            if ((!wave_on || div_done) && sample_pos_next == '0) begin
              steps_done_next = steps_inc;
              if (steps_inc >= step_target) begin
                clr = 1'b1;
                if (mode_reg[5]) tip_phase_next = PH_DELAY2;
                else running_next = 1'b0;
              end
            end
          end else begin
            case (tip_phase)
              PH_EXTEND: begin
                pid_enable_next = 1'b1;
                if (sz > 17'(ZLIM)) begin
                  tip_phase_next = PH_RETRACT;
                  confirm_count_next = confirm_ticks;
                end
                if (in_w.error_positive) confirm_count_next = confirm_count_next - 16'd1;
                if (confirm_count_next == '0) begin
                  tip_phase_next = PH_READY;
                  running_next = 1'b0;
                  confirm_count_next = confirm_ticks;
                end
              end
              PH_RETRACT: begin
                if (sci > 17'sd0) begin
                  capture = 1'b1;
                  gain_neg_next = ci_eff < 16'sd0;
                  saved_ci_next = ci_eff;
                  saved_cp_next = cp_eff;
                  gain_override_next = 1'b1;
                end else if (sz < -17'(ZLIM)) begin
                  pid_enable_next = 1'b0;
                  gain_override_next = 1'b0;
                  restored = 1'b1;
                  delay_count_next = {1'b0, delay_ticks};
                  tip_phase_next = PH_DELAY1;
                end
              end
              PH_DELAY1: begin
                if (delay_count == '0) begin
                  sample_pos_next = '0;
                  steps_done_next = '0;
                  delay_count_next = {1'b0, delay_ticks};
                  tip_phase_next = PH_STEP;
                end else delay_count_next = delay_count - 17'd1;
              end
              PH_DELAY2: begin
                if (delay_count == '0) tip_phase_next = PH_EXTEND;
                else delay_count_next = delay_count - 17'd1;
              end
              default: ;
            endcase
          end
        end
      end
      OP_START: begin
        sample_pos_next = '0;
        steps_done_next = '0;
        confirm_count_next = confirm_ticks;
        tip_phase_next = PH_EXTEND;
        divider_count_next = {1'b0, slow_down};
        running_next = 1'b1;
      end
      OP_STOP: begin
        if (sci < 17'sd0) begin
          gain_override_next = 1'b0;
          restored = 1'b1;
        end
        pid_enable_next = 1'b1;
        running_next = 1'b0;
      end
      default: ;
    endcase
    // Drives to be zeroed after the table read are applied last in the back part.
    nxz = clr;
    nyz = clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= '0; wave_length <= 13'd1; phase_offset <= '0; slow_down <= 16'd1;
      step_target <= 16'd1; delay_ticks <= '0; confirm_ticks <= 16'd1; ci_multiplier <= 8'd1;
      tip_phase <= PH_EXTEND; running <= 1'b0; gain_neg <= 1'b0; pid_enable <= 1'b0;
      gain_override <= 1'b0; confirm_count <= '0; steps_done <= '0; delay_count <= '0;
      divider_count <= '0; sample_pos <= '0; saved_ci <= '0; saved_cp <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MOVER_MODE:    mode_reg <= cfg_data[5:0];
          REG_WAVE_LENGTH:   wave_length <= cfg_data[12:0];
          REG_PHASE_OFFSET:  phase_offset <= cfg_data[11:0];
          REG_SLOW_DOWN:     slow_down <= cfg_data;
          REG_STEP_TARGET:   step_target <= cfg_data;
          REG_DELAY_TICKS:   delay_ticks <= cfg_data;
          REG_CONFIRM_TICKS: confirm_ticks <= cfg_data;
          REG_CI_MULTIPLIER: ci_multiplier <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_take) begin
        tip_phase <= tip_phase_next; running <= running_next; gain_neg <= gain_neg_next;
        pid_enable <= pid_enable_next; gain_override <= gain_override_next;
        confirm_count <= confirm_count_next; steps_done <= steps_done_next;
        delay_count <= delay_count_next; divider_count <= divider_count_next;
        sample_pos <= sample_pos_next; saved_ci <= saved_ci_next; saved_cp <= saved_cp_next;
      end
    end
  end

  always_comb begin
    job.operation   = in_w.operation;
    job.drive_sel   = {dy_w, dx_w};
    job.drive_neg   = {dy_n, dx_n};
    job.drive_zero  = {dy_z, dx_z};
    job.rd_x        = rdx;
    job.rd_y        = rdy;
    job.next_x_zero = nxz;
    job.next_y_zero = nyz;
    job.clear_after = clr;
    if (restored) begin
      job.ci_req = saved_ci_next; job.cp_req = saved_cp_next;
    end else if (gain_override_next) begin
      // A capture only happens with the override off, so the captured gain is the input's.
      job.ci_req = capture ? ovr_cap : ovr_now;
      job.cp_req = 16'sd0;
    end else begin
      job.ci_req = in_w.ci_now; job.cp_req = in_w.cp_now;
    end
    job.feedback_on = pid_enable_next;
    job.phase       = tip_phase_next;
    job.busy        = running_next;
    rd_x_en   = in_take && rdx;
    rd_y_en   = in_take && rdy;
    rd_x_addr = rx_a[AW-1:0];
    rd_y_addr = ry_a[AW-1:0];
  end
endmodule

@@ rtl/taas_back.sv @@
// Back part: applies table data to the held drives and forms the result word.
module taas_back
  import taas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  input  logic [15:0] x_data,
  input  logic [15:0] y_data,
  input  logic        out_take,
  output logic        out_valid,
  output out_word_t   out_w
);
  logic [15:0] drive_x, drive_y, x_next, y_next;

  always_comb begin
    x_next = drive_x;
    y_next = drive_y;
    if (job.drive_sel[0]) x_next = job.drive_zero[0] ? 16'd0 :
                                   (job.drive_neg[0] ? 16'(-x_data) : x_data);
    if (job.drive_sel[1]) y_next = job.drive_zero[1] ? 16'd0 :
                                   (job.drive_neg[1] ? 16'(-y_data) : y_data);
    if (job.next_x_zero) x_next = '0;
    if (job.next_y_zero) y_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      drive_x <= '0;
      drive_y <= '0;
    end else begin
      if (job_valid) begin
        drive_x <= x_next;
        drive_y <= y_next;
        out_valid <= 1'b1;
        out_w <= '{x_drive: x_next, y_drive: y_next, ci_request: job.ci_req,
                   cp_request: job.cp_req, feedback_on: job.feedback_on,
                   phase: job.phase, busy_res: job.busy};
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

@@ rtl/tip_auto_approach_sequencer.sv @@
// Top level of the tip auto-approach sequencer.
// The table read and the queue entry are registered when a word is accepted; the result
// word then enters the output register once that register is free or being taken.
// Throughput: one word per cycle unless out_stall holds a full output; one table read port per axis.
// The input stalls only when the queue entry and the output register are full and out_stall is high.
// Reset (rst, synchronous) clears control state and registers; table contents are undefined.
module tip_auto_approach_sequencer
  import taas_pkg::*;
#(
  parameter int Z_LIMIT = 30000
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data
);
  localparam int AW = $clog2(WAVE_DEPTH);

  job_t job_f, job_q;
  logic job_valid;
  logic in_take, out_take;
  logic rdx_en, rdy_en;
  logic [AW-1:0] rdx_addr, rdy_addr, wr_addr;
  logic [15:0] x_data, y_data;
  logic wr_en;

  // The back stage advances only if the output is free; a single-entry queue holds a job.
  logic back_move;
  assign out_take  = out_valid && !out_stall;
  assign back_move = !out_valid || out_take;
  assign in_stall  = job_valid && !back_move;
  assign in_take   = in_valid && !in_stall;

  assign wr_en   = in_take && (op_t'(in_data.operation) == OP_LOAD);
  assign wr_addr = in_data.wave_index;

  taas_front #(.AW(AW), .ZLIM(Z_LIMIT)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_take, .in_w(in_data),
    .job(job_f), .rd_x_en(rdx_en), .rd_y_en(rdy_en),
    .rd_x_addr(rdx_addr), .rd_y_addr(rdy_addr)
  );

  taas_ram #(.WIDTH(16), .DEPTH(WAVE_DEPTH)) u_ram_x (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(in_data.wave_sample),
    .re(rdx_en), .raddr(rdx_addr), .rdata(x_data)
  );
  taas_ram #(.WIDTH(16), .DEPTH(WAVE_DEPTH)) u_ram_y (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(in_data.wave_sample),
    .re(rdy_en), .raddr(rdy_addr), .rdata(y_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_take) begin
      job_valid <= 1'b1;
      job_q <= job_f;
    end else if (back_move) begin
      job_valid <= 1'b0;
    end
  end

  taas_back u_back (
    .clk, .rst, .job_valid(job_valid && back_move), .job(job_q),
    .x_data, .y_data, .out_take, .out_valid, .out_w(out_data)
  );

`ifndef SYNTH
  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !in_take) else $error("word taken while stalled");
  a_job_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (job_valid && back_move) |=> out_valid) else $error("job lost before output");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.phase <= 3'd5)) else $error("phase out of range");
`endif
endmodule

@@ verif/tip_auto_approach_sequencer_test.sv @@
// Testbench for the tip auto-approach sequencer: random and directed words checked against a shadow model.
`timescale 1ns / 100ps

module tip_auto_approach_sequencer_test;
  import taas_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int IN_W = $bits(in_word_t);

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_word_t        out_data;

  tip_auto_approach_sequencer DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the registers.
  logic [5:0]  mode_r = 6'd0;
  int          wave_len_r = 1;
  int          offset_r = 0;
  int          slow_r = 1;
  logic [15:0] target_r = 16'd1;
  int          delay_r = 0;
  logic [15:0] confirm_r = 16'd1;
  int          mult_r = 1;

  // Shadow copy of the sequencer state.
  logic [15:0] wave_mem [0:4095];
  phase_t      tip_ph = PH_EXTEND;
  logic        busy = 1'b0;
  logic [15:0] confirm_cnt = 16'd0;
  int          wait_count = 0;
  int          sample_pos = 0;
  int          divider_cnt = 0;
  logic [15:0] steps_done = 16'd0;
  int          saved_ci = 0;
  int          saved_cp = 0;
  logic        gain_neg = 1'b0;
  logic        pid_on = 1'b0;
  logic        gain_ovr = 1'b0;
  logic        just_restored = 1'b0;
  logic [15:0] hold_x = 16'd0;
  logic [15:0] hold_y = 16'd0;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        errors = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      word_taken = 1'b0;

  function automatic logic [15:0] table_at(int a);
    return wave_mem[a & 'hFFF];
  endfunction

  function automatic int override_gain();
    int p;
    p = -saved_ci * mult_r;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p;
  endfunction

  function automatic void mover_step();
    int  pos, len, t;
    logic iw;
    if (mode_r[4]) begin
      pos = sample_pos;
      len = wave_len_r;
      t = pos + offset_r;
      iw = mode_r[3];
      if (t >= len) t -= len;
      case (mode_r[2:0])
        3'd1: begin
          hold_x = table_at(pos);
          if (iw) hold_y = table_at(t);
        end
        3'd2: begin
          if (iw) begin
            hold_x = table_at(len - pos - 1);
            hold_y = table_at(len - t - 1);
          end else begin
            hold_x = 16'd0 - table_at(pos);
          end
        end
        3'd3: hold_y = table_at(pos);
        3'd4: hold_y = 16'd0 - table_at(pos);
        3'd0: begin
          hold_x = 16'd0;
          hold_y = 16'd0;
        end
        default: ;
      endcase
      divider_cnt--;
      if (divider_cnt > 0) return;
      divider_cnt = slow_r;
      sample_pos++;
      if (sample_pos >= wave_len_r || sample_pos >= 4096) sample_pos = 0;
    end
    if (sample_pos == 0) begin
      steps_done = steps_done + 16'd1;
      if (steps_done >= target_r) begin
        hold_x = 16'd0;
        hold_y = 16'd0;
        if (mode_r[5]) tip_ph = PH_DELAY2;
        else busy = 1'b0;
      end
    end
  endfunction

  function automatic void approach_step(int z, logic errpos, int ci, int cp);
    int sz, sci;
    sz = gain_neg ? -z : z;
    sci = gain_neg ? -ci : ci;
    case (tip_ph)
      PH_EXTEND: begin
        pid_on = 1'b1;
        if (sz > 30000) begin
          tip_ph = PH_RETRACT;
          confirm_cnt = confirm_r;
        end
        if (errpos) confirm_cnt = confirm_cnt - 16'd1;
        if (confirm_cnt == 16'd0) begin
          tip_ph = PH_READY;
          busy = 1'b0;
          confirm_cnt = confirm_r;
        end
      end
      PH_RETRACT: begin
        if (sci > 0) begin
          gain_neg = ci < 0;
          saved_ci = ci;
          saved_cp = cp;
          gain_ovr = 1'b1;
        end else if (sz < -30000) begin
          pid_on = 1'b0;
          gain_ovr = 1'b0;
          just_restored = 1'b1;
          wait_count = delay_r;
          tip_ph = PH_DELAY1;
        end
      end
      PH_DELAY1: begin
        if (wait_count == 0) begin
          sample_pos = 0;
          steps_done = 16'd0;
          wait_count = delay_r;
          tip_ph = PH_STEP;
        end else begin
          wait_count--;
        end
      end
      PH_STEP: mover_step();
      PH_DELAY2: begin
        if (wait_count == 0) tip_ph = PH_EXTEND;
        else wait_count--;
      end
      default: ;
    endcase
  endfunction

  function automatic out_word_t sequencer_step(in_word_t w);
    int z, ci, cp;
    out_word_t r;
    z = int'($signed(w.z_position));
    ci = gain_ovr ? override_gain() : int'($signed(w.ci_now));
    cp = gain_ovr ? 0 : int'($signed(w.cp_now));
    just_restored = 1'b0;
    case (op_t'(w.operation))
      OP_TICK: begin
        if (busy) begin
          if (mode_r[5]) approach_step(z, w.error_positive, ci, cp);
          else mover_step();
        end
      end
      OP_START: begin
        sample_pos = 0;
        steps_done = 16'd0;
        confirm_cnt = confirm_r;
        tip_ph = PH_EXTEND;
        divider_cnt = slow_r;
        busy = 1'b1;
      end
      OP_STOP: begin
        if ((gain_neg ? -ci : ci) < 0) begin
          gain_ovr = 1'b0;
          just_restored = 1'b1;
        end
        pid_on = 1'b1;
        busy = 1'b0;
      end
      default: wave_mem[w.wave_index] = w.wave_sample;
    endcase
    if (just_restored) begin
      r.ci_request = 16'(saved_ci);
      r.cp_request = 16'(saved_cp);
    end else if (gain_ovr) begin
      r.ci_request = 16'(override_gain());
      r.cp_request = 16'd0;
    end else begin
      r.ci_request = w.ci_now;
      r.cp_request = w.cp_now;
    end
    r.x_drive = hold_x;
    r.y_drive = hold_y;
    r.feedback_on = pid_on;
    r.phase = tip_ph;
    r.busy_res = busy;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Input driver: a word stays on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_words.push_back(sequencer_step(in_data));
      void'(pending_words.pop_front());
      word_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || word_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_words[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    word_taken = 1'b0;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Output monitor.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_data.x_drive !== want.x_drive)
          report_mismatch("x_drive", out_data.x_drive, want.x_drive);
        if (out_data.y_drive !== want.y_drive)
          report_mismatch("y_drive", out_data.y_drive, want.y_drive);
        if (out_data.ci_request !== want.ci_request)
          report_mismatch("ci_request", out_data.ci_request, want.ci_request);
        if (out_data.cp_request !== want.cp_request)
          report_mismatch("cp_request", out_data.cp_request, want.cp_request);
        if (out_data.feedback_on !== want.feedback_on)
          report_mismatch("feedback_on", out_data.feedback_on, want.feedback_on);
        if (out_data.phase !== want.phase)
          report_mismatch("phase", out_data.phase, want.phase);
        if (out_data.busy_res !== want.busy_res)
          report_mismatch("busy_res", out_data.busy_res, want.busy_res);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_word_t make_word(op_t op);
    in_word_t w;
    int pick;
    w = IN_W'({$urandom, $urandom, $urandom});
    w.operation = op;
    pick = $urandom_range(99);
    // Most Z values sit past the limits so the approach reaches retract and delay.
    if (pick < 35) w.z_position = 16'($urandom_range(30001, 32767));
    else if (pick < 70) w.z_position = 16'(-$urandom_range(30001, 32768));
    return w;
  endfunction

  function automatic void queue_load(int addr, logic [15:0] value);
    in_word_t w;
    w = make_word(OP_LOAD);
    w.wave_index = 12'(addr);
    w.wave_sample = value;
    pending_words.push_back(w);
  endfunction

  task automatic wait_quiet();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(int mode, int len, int off, int slow, int tgt, int dly,
                                int conf, int mult);
    int vals [8];
    vals = '{mode, len, off, slow, tgt, dly, conf, mult};
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= CFG_W'(vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    mode_r = 6'(mode);
    wave_len_r = len;
    offset_r = off;
    slow_r = slow;
    target_r = 16'(tgt);
    delay_r = dly;
    confirm_r = 16'(conf);
    mult_r = mult;
  endtask

  task automatic run_phase(int mode, int len, int off, int slow, int tgt, int dly, int conf,
                           int mult, int count);
    int t, pick;
    wait_quiet();
    write_settings(mode, len, off, slow, tgt, dly, conf, mult);
    pending_words.push_back(make_word(OP_STOP));
    // Every table address the mover can read in this setting is loaded first.
    if (mode[4]) begin
      for (int p = 0; p < len; p++) begin
        t = p + off;
        if (t >= len) t -= len;
        queue_load(p, 16'($urandom));
        queue_load(t, 16'($urandom));
        queue_load(len - p - 1, 16'($urandom));
        queue_load(len - t - 1, (p == 0) ? 16'h8000 : 16'($urandom));
      end
    end
    pending_words.push_back(make_word(OP_START));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 82) pending_words.push_back(make_word(OP_TICK));
      else if (pick < 90) pending_words.push_back(make_word(OP_START));
      else if (pick < 95) pending_words.push_back(make_word(OP_STOP));
      else pending_words.push_back(make_word(OP_LOAD));
    end
  endtask

  initial begin
    in_word_t w;
    int mode, len;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 10;
    recv_stall_pct = 80;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words under reset settings: extremes, every operation, idle ticks.
    queue_load(0, 16'h7FFF);
    queue_load(4095, 16'h8000);
    w = make_word(OP_TICK);
    w.z_position = 16'h7FFF;
    w.ci_now = 16'h8000;
    w.cp_now = 16'h7FFF;
    pending_words.push_back(w);
    w.z_position = 16'h8000;
    w.ci_now = 16'h7FFF;
    w.cp_now = 16'h8000;
    pending_words.push_back(w);
    pending_words.push_back(make_word(OP_START));
    for (int i = 0; i < 4; i++) pending_words.push_back(make_word(OP_TICK));
    w = make_word(OP_STOP);
    w.ci_now = 16'h8000;
    pending_words.push_back(w);
    w = make_word(OP_STOP);
    w.ci_now = 16'h7FFF;
    pending_words.push_back(w);
    pending_words.push_back(make_word(OP_TICK));

    run_phase(6'b010001, 5, 2, 2, 3, 1, 2, 1, 170);
    run_phase(6'b111010, 4, 4095, 1, 2, 3, 3, 255, 170);
    run_phase(6'b100100, 4096, 0, 65535, 65535, 65535, 65535, 0, 120);
    run_phase(6'b111111, 1, 0, 1, 0, 0, 1, 1, 170);
    send_idle_pct = 80;
    recv_stall_pct = 10;
    run_phase(6'b111011, 8, 3, 3, 2, 2, 2, 2, 170);
    run_phase(6'b110100, 3, 1, 1, 1, 0, 1, 0, 170);
    run_phase(6'b110010, 2, 0, 1, 65535, 1, 1, 3, 150);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int ph = 0; ph < 4; ph++) begin
      mode = $urandom_range(63);
      if (ph < 2) mode[5:4] = 2'b11;
      len = mode[4] ? $urandom_range(1, 8) : $urandom_range(1, 4096);
      run_phase(mode, len, $urandom_range(4095), $urandom_range(1, 3), $urandom_range(4),
                $urandom_range(3), $urandom_range(1, 4), $urandom_range(255), 120);
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/taas_pkg.sv
rtl/taas_ram.sv
rtl/taas_front.sv
rtl/taas_back.sv
rtl/tip_auto_approach_sequencer.sv
verif/tip_auto_approach_sequencer_test.sv
